FILE: rtl/core/nau_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nau_pkg - shared types and constants of the neuron activation unit
// Word formats, pipeline stage numbering, mode and finish codes, and the
// sigmoid table, which is built once at elaboration.
// ============================================================================
package nau_pkg;

    // Word formats (signed Q7.16 by default)
    localparam int WORD_BITS    = 24;
    localparam int FRAC_BITS    = 16;
    localparam int TABLE_LOG2   = 8;
    localparam int TABLE_ENTRIES = 1 << TABLE_LOG2;
    localparam int TAYLOR_TERMS = 24;

    // Derived widths
    localparam int TBL_BITS   = FRAC_BITS + 1;                   // table entry, up to one
    localparam int ADDR_BITS  = WORD_BITS + 1;                   // magnitude, doubled for tanh
    localparam int POS_FRAC   = FRAC_BITS + 3 - TABLE_LOG2;      // interpolation fraction bits
    localparam int IDX_BITS   = ADDR_BITS - POS_FRAC;
    localparam int DIV_BITS   = WORD_BITS + 1;                   // dividend of the 1/100 unit
    localparam int DIV_SHIFT  = DIV_BITS + 7;
    localparam int RECIP_BITS = DIV_BITS + 1;
    localparam int QUO_BITS   = DIV_BITS - 6;
    localparam int RES_BITS   = WORD_BITS + 2;                   // result before clamping

    // Arithmetic constants
    localparam int ONE_VAL    = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 50;
    localparam int DIVISOR    = 100;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << DIV_SHIFT) / 64'd100;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_WIDE[RECIP_BITS-1:0];
    localparam longint SAT_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    // Pipeline stages
    localparam int NUM_STAGES = 8;
    localparam int STG_FRONT  = 0;   // input register, magnitude
    localparam int STG_READ   = 1;   // table read
    localparam int STG_MUL    = 2;   // interpolation multiply
    localparam int STG_SUM    = 3;   // interpolation add
    localparam int STG_SEL    = 4;   // function select
    localparam int STG_DMUL   = 5;   // reciprocal multiply
    localparam int STG_DFIX   = 6;   // quotient correction
    localparam int STG_OUT    = 7;   // finish, clamp, output register

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef enum logic [1:0] {
        MODE_SIGMOID    = 2'd0,
        MODE_LEAKY_RELU = 2'd1,
        MODE_TANH       = 2'd2,
        MODE_PASS       = 2'd3
    } t_mode;

    // How the last stage forms the result
    typedef enum logic [1:0] {
        FIN_DIRECT     = 2'd0,
        FIN_NEG_Q      = 2'd1,
        FIN_ONE_PLUS_Q = 2'd2
    } t_fin;

    typedef struct packed {
        t_mode                mode;
        logic                 neg;
        logic                 last;
        logic [WORD_BITS-1:0] x;
    } t_side;

    typedef struct packed {
        t_fin                fin;
        logic [DIV_BITS-1:0] v;
    } t_relu;

    typedef struct packed {
        t_fin                fin;
        logic                last;
        logic [RES_BITS-1:0] y;
        logic [DIV_BITS-1:0] v;
    } t_tail;

    typedef logic [TBL_BITS-1:0] t_tbl_word;
    typedef logic [TABLE_ENTRIES:0][TBL_BITS-1:0] t_sig_table;

    // Shift-subtract division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid points over |x| in [0, 8]: round(one / (1 + e^(-8k/N))), e^(-8/N) in Q32
    function automatic t_sig_table build_sig_table();
        t_sig_table  tbl;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] num;
        tbl  = '0;
        h    = 64'd1 << (35 - TABLE_LOG2);
        term = 64'd1 << 32;
        r    = 64'd1 << 32;
        p    = 64'd1 << 32;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = div_u64((term * h) >> 32, 64'(k));
            r    = k[0] ? (r - term) : (r + term);
        end
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            den    = (64'd1 << 32) + p;
            num    = (64'd1 << (FRAC_BITS + 32)) + (den >> 1);
            tbl[k] = TBL_BITS'(div_u64(num, den));
            p      = (k == 0) ? r : ((p * r + (64'd1 << 31)) >> 32);
        end
        return tbl;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

endpackage

FILE: rtl/core/nau_sig_interp.sv
`timescale 1ns / 1ps
// ============================================================================
// nau_sig_interp - sigmoid table lookup with linear interpolation
// Three stages: read two neighboring points, multiply the step by the
// fraction, add to the lower point. Magnitudes past the table read the top.
// ============================================================================
module nau_sig_interp (
    input  logic                                 i_clk,
    input  nau_pkg::t_stage_en                   i_en,
    input  logic [nau_pkg::ADDR_BITS-1:0]        i_addr,
    output logic [nau_pkg::TBL_BITS-1:0]         o_sig
);

    localparam int PROD_BITS = nau_pkg::TBL_BITS + nau_pkg::POS_FRAC;

    logic [nau_pkg::IDX_BITS-1:0]   idx;
    logic                           beyond;
    logic [nau_pkg::TABLE_LOG2-1:0] lo_sel;
    logic [nau_pkg::TABLE_LOG2:0]   hi_sel;
    nau_pkg::t_tbl_word             lo_word;
    nau_pkg::t_tbl_word             hi_word;
    nau_pkg::t_tbl_word             step;

    nau_pkg::t_tbl_word             r_lo;
    nau_pkg::t_tbl_word             r_hi;
    logic [nau_pkg::POS_FRAC-1:0]   r_frac;
    nau_pkg::t_tbl_word             r_base;
    logic [PROD_BITS-1:0]           r_prod;
    nau_pkg::t_tbl_word             r_sig;

    // Split the position into segment index and fraction
    always_comb begin
        idx     = i_addr[nau_pkg::ADDR_BITS-1:nau_pkg::POS_FRAC];
        beyond  = |idx[nau_pkg::IDX_BITS-1:nau_pkg::TABLE_LOG2];
        lo_sel  = idx[nau_pkg::TABLE_LOG2-1:0];
        hi_sel  = {1'b0, lo_sel} + (nau_pkg::TABLE_LOG2+1)'(1);
        lo_word = beyond ? nau_pkg::SIG_TABLE[nau_pkg::TABLE_ENTRIES]
                         : nau_pkg::SIG_TABLE[lo_sel];
        hi_word = beyond ? nau_pkg::SIG_TABLE[nau_pkg::TABLE_ENTRIES]
                         : nau_pkg::SIG_TABLE[hi_sel];
        step    = r_hi - r_lo;
    end

    // Read, multiply, add
    always_ff @(posedge i_clk) begin
        if (i_en[nau_pkg::STG_READ]) begin
            r_lo   <= lo_word;
            r_hi   <= hi_word;
            r_frac <= i_addr[nau_pkg::POS_FRAC-1:0];
        end
        if (i_en[nau_pkg::STG_MUL]) begin
            r_base <= r_lo;
            r_prod <= PROD_BITS'(step) * PROD_BITS'(r_frac);
        end
        if (i_en[nau_pkg::STG_SUM]) begin
            r_sig <= r_base + nau_pkg::TBL_BITS'(r_prod >> nau_pkg::POS_FRAC);
        end
    end

    assign o_sig = r_sig;

endmodule

FILE: rtl/core/nau_div100.sv
`timescale 1ns / 1ps
// ============================================================================
// nau_div100 - floor division by one hundred
// Multiply by a scaled reciprocal, then fix the estimate, which is at most
// one short, with a single compare on the low bits of the remainder.
// ============================================================================
module nau_div100 (
    input  logic                                 i_clk,
    input  nau_pkg::t_stage_en                   i_en,
    input  logic [nau_pkg::DIV_BITS-1:0]         i_dividend,
    output logic [nau_pkg::QUO_BITS-1:0]         o_quotient
);

    localparam int MPROD_BITS = nau_pkg::DIV_BITS + nau_pkg::RECIP_BITS;

    logic [nau_pkg::QUO_BITS-1:0] estimate;
    logic [7:0]                   est_low;
    logic [7:0]                   rem_low;

    logic [nau_pkg::DIV_BITS-1:0] r_num;
    logic [MPROD_BITS-1:0]        r_prod;
    logic [nau_pkg::QUO_BITS-1:0] r_quo;

    // Remainder stays below twice the divisor, so eight bits hold it
    always_comb begin
        estimate = nau_pkg::QUO_BITS'(r_prod >> nau_pkg::DIV_SHIFT);
        est_low  = 8'(estimate[7:0] * 8'(nau_pkg::DIVISOR));
        rem_low  = r_num[7:0] - est_low;
    end

    // Reciprocal multiply, then correct
    always_ff @(posedge i_clk) begin
        if (i_en[nau_pkg::STG_DMUL]) begin
            r_num  <= i_dividend;
            r_prod <= MPROD_BITS'(i_dividend) * MPROD_BITS'(nau_pkg::DIV_RECIP);
        end
        if (i_en[nau_pkg::STG_DFIX]) begin
            r_quo <= estimate
                   + nau_pkg::QUO_BITS'(rem_low >= 8'(nau_pkg::DIVISOR));
        end
    end

    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/neuron_activation_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// neuron_activation_unit - sigmoid, clipped leaky ReLU, tanh or pass-through per sample
// Applies the function picked by the mode register to each signed Q7.16
// sample, saturates the result and passes the vector-end flag along.
// ============================================================================
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------
//  input   | i_in_valid o_in_ready i_sample_in i_last_in | i_in_valid & o_in_ready
//  output  | o_out_valid i_out_ready o_sample_out o_last_out | o_out_valid & i_out_ready
//  config  | i_cfg_we i_cfg_wdata                       | i_cfg_we
//
//  One sample per cycle sustained while i_out_ready holds. The pipeline has eight
//  stages from the input register to the output register; table read, interpolation
//  multiply and reciprocal multiply for the 0.01 scale each have their own stage.
//  Synchronous active-low reset empties the pipeline and sets sigmoid mode;
//  the table is constant logic and needs no fill.
//  Each stage advances when empty or when the next stage advances, so bubbles
//  close up under a stall and o_in_ready drops only with all stages full.
//
module neuron_activation_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [nau_pkg::WORD_BITS-1:0] i_sample_in,
    input  logic                                 i_last_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [nau_pkg::WORD_BITS-1:0] o_sample_out,
    output logic                                 o_last_out
);

    localparam int W      = nau_pkg::WORD_BITS;
    localparam int RB     = nau_pkg::RES_BITS;
    localparam int M_BITS = nau_pkg::TBL_BITS + 2;
    localparam logic signed [RB-1:0] Y_MAX = RB'(nau_pkg::SAT_MAX);
    localparam logic signed [RB-1:0] Y_MIN = RB'(nau_pkg::SAT_MIN);

    nau_pkg::t_mode                  r_mode;
    logic [nau_pkg::NUM_STAGES-1:0]  r_valid;
    logic [nau_pkg::NUM_STAGES-1:0]  n_valid;
    nau_pkg::t_stage_en              en;

    nau_pkg::t_side                  r_side [nau_pkg::STG_FRONT:nau_pkg::STG_SUM];
    logic [W-1:0]                    r_mag;
    nau_pkg::t_relu                  r_relu [nau_pkg::STG_READ:nau_pkg::STG_SUM];
    nau_pkg::t_tail                  r_tail [nau_pkg::STG_SEL:nau_pkg::STG_DFIX];
    logic signed [W-1:0]             r_sample;
    logic                            r_last;

    logic [W-1:0]                    raw_in;
    logic [W-1:0]                    mag_in;
    logic [nau_pkg::ADDR_BITS-1:0]   lookup_addr;
    nau_pkg::t_relu                  n_relu;
    logic [nau_pkg::TBL_BITS-1:0]    sig;
    nau_pkg::t_side                  sel_side;
    nau_pkg::t_relu                  sel_relu;
    logic signed [M_BITS-1:0]        tanh_raw;
    logic [M_BITS-2:0]               tanh_mag;
    nau_pkg::t_tail                  n_tail;
    logic [nau_pkg::QUO_BITS-1:0]    quo;
    logic signed [RB-1:0]            q_ext;
    logic signed [RB-1:0]            fin_y;
    logic signed [W-1:0]             n_sample;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nau_pkg::MODE_SIGMOID;
        end else if (i_cfg_we) begin
            r_mode <= nau_pkg::t_mode'(i_cfg_wdata);
        end
    end

    // Stage enables: advance when empty or when the next stage advances
    always_comb begin
        en[nau_pkg::STG_OUT] = !r_valid[nau_pkg::STG_OUT] || i_out_ready;
        for (int k = nau_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = {r_valid[nau_pkg::NUM_STAGES-2:0], i_in_valid};
    end

    assign o_in_ready = en[nau_pkg::STG_FRONT];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < nau_pkg::NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    // Front: capture the sample magnitude
    always_comb begin
        raw_in = i_sample_in;
        mag_in = raw_in[W-1] ? (~raw_in + W'(1)) : raw_in;
    end

    always_ff @(posedge i_clk) begin
        if (en[nau_pkg::STG_FRONT]) begin
            r_mag <= mag_in;
        end
    end

    // Table address (doubled for tanh) and leaky ReLU dividend
    always_comb begin
        lookup_addr = (r_side[nau_pkg::STG_FRONT].mode == nau_pkg::MODE_TANH)
                    ? {r_mag, 1'b0} : {1'b0, r_mag};
        if (r_side[nau_pkg::STG_FRONT].neg) begin
            n_relu.fin = nau_pkg::FIN_NEG_Q;
            n_relu.v   = nau_pkg::DIV_BITS'(r_mag)
                       + nau_pkg::DIV_BITS'(nau_pkg::ROUND_HALF);
        end else if (r_mag > W'(nau_pkg::ONE_VAL)) begin
            n_relu.fin = nau_pkg::FIN_ONE_PLUS_Q;
            n_relu.v   = nau_pkg::DIV_BITS'(r_mag)
                       - nau_pkg::DIV_BITS'(nau_pkg::ONE_VAL - nau_pkg::ROUND_HALF);
        end else begin
            n_relu.fin = nau_pkg::FIN_DIRECT;
            n_relu.v   = '0;
        end
    end

    // Capture the sample at the front and carry it alongside the
    // interpolation stages
    always_ff @(posedge i_clk) begin
        if (en[nau_pkg::STG_FRONT]) begin
            r_side[nau_pkg::STG_FRONT] <= '{mode: r_mode, neg: raw_in[W-1],
                                            last: i_last_in, x: raw_in};
        end
        if (en[nau_pkg::STG_READ]) begin
            r_relu[nau_pkg::STG_READ] <= n_relu;
        end
        for (int k = nau_pkg::STG_READ; k <= nau_pkg::STG_SUM; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        for (int k = nau_pkg::STG_MUL; k <= nau_pkg::STG_SUM; k++) begin
            if (en[k]) begin
                r_relu[k] <= r_relu[k-1];
            end
        end
    end

    nau_sig_interp u_interp (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (lookup_addr),
        .o_sig  (sig)
    );

    // Select: form the direct result or the value to scale by 0.01
    always_comb begin
        sel_side = r_side[nau_pkg::STG_SUM];
        sel_relu = r_relu[nau_pkg::STG_SUM];
        tanh_raw = $signed({1'b0, sig, 1'b0}) - $signed(M_BITS'(nau_pkg::ONE_VAL));
        tanh_mag = tanh_raw[M_BITS-1] ? '0 : tanh_raw[M_BITS-2:0];
        n_tail.fin  = nau_pkg::FIN_DIRECT;
        n_tail.last = sel_side.last;
        n_tail.y    = RB'($signed(sel_side.x));
        n_tail.v    = '0;
        unique case (sel_side.mode)
            nau_pkg::MODE_SIGMOID: begin
                n_tail.y = sel_side.neg ? (RB'(nau_pkg::ONE_VAL) - RB'(sig)) : RB'(sig);
            end
            nau_pkg::MODE_LEAKY_RELU: begin
                n_tail.fin = sel_relu.fin;
                n_tail.v   = sel_relu.v;
            end
            nau_pkg::MODE_TANH: begin
                if (sel_side.neg) begin
                    n_tail.fin = nau_pkg::FIN_NEG_Q;
                    n_tail.v   = nau_pkg::DIV_BITS'(tanh_mag)
                               + nau_pkg::DIV_BITS'(nau_pkg::ROUND_HALF);
                end else begin
                    n_tail.y = RB'(tanh_mag);
                end
            end
            nau_pkg::MODE_PASS: begin
                n_tail.y = RB'($signed(sel_side.x));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[nau_pkg::STG_SEL]) begin
            r_tail[nau_pkg::STG_SEL] <= n_tail;
        end
        for (int k = nau_pkg::STG_DMUL; k <= nau_pkg::STG_DFIX; k++) begin
            if (en[k]) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    nau_div100 u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_tail[nau_pkg::STG_SEL].v),
        .o_quotient (quo)
    );

    // Finish: apply sign or offset to the quotient, then clamp
    always_comb begin
        q_ext = RB'(quo);
        unique case (r_tail[nau_pkg::STG_DFIX].fin)
            nau_pkg::FIN_DIRECT:     fin_y = r_tail[nau_pkg::STG_DFIX].y;
            nau_pkg::FIN_NEG_Q:      fin_y = -q_ext;
            nau_pkg::FIN_ONE_PLUS_Q: fin_y = RB'(nau_pkg::ONE_VAL) + q_ext;
            default:                 fin_y = r_tail[nau_pkg::STG_DFIX].y;
        endcase
        if (fin_y > Y_MAX) begin
            n_sample = Y_MAX[W-1:0];
        end else if (fin_y < Y_MIN) begin
            n_sample = Y_MIN[W-1:0];
        end else begin
            n_sample = fin_y[W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (en[nau_pkg::STG_OUT]) begin
            r_sample <= n_sample;
            r_last   <= r_tail[nau_pkg::STG_DFIX].last;
        end
    end

    assign o_out_valid  = r_valid[nau_pkg::STG_OUT];
    assign o_sample_out = r_sample;
    assign o_last_out   = r_last;

    // An empty output stage lets every stage advance
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[nau_pkg::STG_OUT] |-> o_in_ready)
        else $error("input not ready with output stage empty");

    // Interpolated sigmoid never exceeds one
    a_sig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[nau_pkg::STG_SUM] |-> (sig <= nau_pkg::TBL_BITS'(nau_pkg::ONE_VAL)))
        else $error("sigmoid lookup above one");

    // Reset empties the pipeline and opens the input
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule
